// ===== design/tpag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpag_pkg
// Shared widths, register indexes, struct types and a helper function for the
// tensor permute address generator.
// ----------------------------------------------------------------------------
package tpag_pkg;

  // tensor geometry
  localparam int AXES     = 4;
  localparam int MAX_AXES = 4;
  localparam int DIM_BITS = 12;
  localparam int SIZE_W   = 13;
  localparam int EXT_W    = DIM_BITS + 1;
  localparam int CMP_W    = (SIZE_W > EXT_W) ? SIZE_W : EXT_W;
  localparam int OFF_W    = 48;
  localparam int ELEM_W   = 64;
  localparam int ORDER_W  = 8;
  localparam int FIELD_W  = 2;

  // configuration port
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 13;

  localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS_ZERO  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS_ONE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS_TWO   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS_THREE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_ORDER      = 3'd4;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd1;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 8'hE4;  // identity order

  // queue depths (powers of two, pointers wrap naturally)
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef logic [DIM_BITS-1:0] pos_t;
  typedef logic [EXT_W-1:0]    ext_t;
  typedef logic [OFF_W-1:0]    off_t;

  // configuration view shared by front and back
  typedef struct packed {
    ext_t [MAX_AXES-1:0] ext;
    off_t [MAX_AXES-1:0] stride;
    logic                order_bad;
    logic                busy;
  } cfg_t;

  // classified transaction between front and back
  typedef struct packed {
    pos_t [MAX_AXES-1:0] pos;
    logic                last;
    logic [ELEM_W-1:0]   elem;
  } mid_t;

  // finished result
  typedef struct packed {
    off_t              off;
    logic [ELEM_W-1:0] elem;
    logic              last;
    logic              err;
  } res_t;

  // effective extent of source axis k: zero acts as one, oversize saturates,
  // unused leading axes act as one
  function automatic ext_t ext_clamp(input logic [SIZE_W-1:0] sz, input int unsigned k);
    logic [CMP_W-1:0] s;
    logic [CMP_W-1:0] lim;
    ext_t             e;
    s   = CMP_W'(sz);
    lim = CMP_W'(1) << DIM_BITS;
    if (k < MAX_AXES - AXES) begin
      e = EXT_W'(1);
    end else if (s == '0) begin
      e = EXT_W'(1);
    end else if (s > lim) begin
      e = lim[EXT_W-1:0];
    end else begin
      e = s[EXT_W-1:0];
    end
    return e;
  endfunction

endpackage

// ===== design/tensor_permute_address_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_permute_address_gen
// Destination offset generator for a permutation of up to four tensor axes.
// Elements enter in source row-major order; each leaves with its offset in
// the permuted tensor, its value, and a last-element flag.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | push / full        | element_in_i
//  result    | empty / pop        | dest_offset_o, element_out_o,
//            |                    | last_of_tensor_o, order_error_o
//  config    | cfg_we_i           | cfg_index_i, cfg_data_i
//
//  One element per cycle sustained while full stays low; a transaction
//  passes the front queue, the product and pair-sum registers and the final
//  sum into the result queue before it shows on the result ports. After
//  reset and after each write to registers 0-4, full stays high while the
//  stride sequencer walks the four destination axes, one multiply per cycle.
//  full also rises when the four-entry front queue fills; the back end stops
//  issuing when the eight-entry result queue plus its pipeline is booked.
// ----------------------------------------------------------------------------
module tensor_permute_address_gen (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [tpag_pkg::ELEM_W-1:0]     element_in_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [tpag_pkg::OFF_W-1:0]      dest_offset_o,
  output logic [tpag_pkg::ELEM_W-1:0]     element_out_o,
  output logic                            last_of_tensor_o,
  output logic                            order_error_o,
  input  logic                            cfg_we_i,
  input  logic [tpag_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpag_pkg::CFG_W-1:0]      cfg_data_i
);

  tpag_pkg::cfg_t  cfg;
  tpag_pkg::mid_t  mid_head;
  tpag_pkg::res_t  res;
  logic            mid_empty;
  logic            mid_pop;

  // registers and stride sequencer
  tpag_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // accept and classify
  tpag_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .element_in_i (element_in_i),
    .full_o       (full),
    .cfg_i        (cfg),
    .mid_pop_i    (mid_pop),
    .mid_empty_o  (mid_empty),
    .mid_head_o   (mid_head)
  );

  // offset arithmetic and result queue
  tpag_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mid_empty_i (mid_empty),
    .mid_head_i  (mid_head),
    .mid_pop_o   (mid_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign dest_offset_o    = res.off;
  assign element_out_o    = res.elem;
  assign last_of_tensor_o = res.last;
  assign order_error_o    = res.err;

endmodule

// ===== design/tpag_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpag_cfg
// Configuration registers and destination stride sequencer. After reset and
// after any write to registers 0-4 the strides are rebuilt, one axis per cycle.
// ----------------------------------------------------------------------------
module tpag_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tpag_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpag_pkg::CFG_W-1:0]       cfg_data_i,
  output tpag_pkg::cfg_t                   cfg_o
);

  logic [tpag_pkg::SIZE_W-1:0]  size_q [tpag_pkg::MAX_AXES];
  logic [tpag_pkg::ORDER_W-1:0] order_q;
  logic                         busy_q, busy_d;
  logic [tpag_pkg::FIELD_W-1:0] step_q, step_d;
  tpag_pkg::off_t               run_q, run_d;
  tpag_pkg::off_t               stride_q [tpag_pkg::MAX_AXES];

  tpag_pkg::ext_t [tpag_pkg::MAX_AXES-1:0] ext;
  logic [tpag_pkg::MAX_AXES-1:0]           seen;
  logic [tpag_pkg::FIELD_W-1:0]            src;
  logic [tpag_pkg::OFF_W+tpag_pkg::EXT_W-1:0] mul_full;
  logic                                    wr_hit;

  // effective extents
  always_comb begin
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      ext[k] = tpag_pkg::ext_clamp(size_q[k], k);
    end
  end

  // permutation check
  always_comb begin
    seen = '0;
    for (int i = 0; i < tpag_pkg::MAX_AXES; i++) begin
      seen[order_q[i*tpag_pkg::FIELD_W +: tpag_pkg::FIELD_W]] = 1'b1;
    end
  end

  // source axis of the destination axis being walked, running product
  assign src      = order_q[{step_q, 1'b0} +: tpag_pkg::FIELD_W];
  assign mul_full = run_q * ext[src];

  assign wr_hit = cfg_we_i && (cfg_index_i <= tpag_pkg::REG_AXIS_ORDER);

  // sequencer next state
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    run_d  = run_q;
    if (wr_hit) begin
      busy_d = 1'b1;
      step_d = tpag_pkg::FIELD_W'(tpag_pkg::MAX_AXES - 1);
      run_d  = tpag_pkg::OFF_W'(1);
    end else if (busy_q) begin
      run_d = mul_full[tpag_pkg::OFF_W-1:0];
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  // registers and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
        size_q[k] <= tpag_pkg::SIZE_RESET;
      end
      order_q <= tpag_pkg::ORDER_RESET;
      busy_q  <= 1'b1;
      step_q  <= tpag_pkg::FIELD_W'(tpag_pkg::MAX_AXES - 1);
      run_q   <= tpag_pkg::OFF_W'(1);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tpag_pkg::REG_SIZE_AXIS_ZERO:  size_q[0] <= cfg_data_i;
          tpag_pkg::REG_SIZE_AXIS_ONE:   size_q[1] <= cfg_data_i;
          tpag_pkg::REG_SIZE_AXIS_TWO:   size_q[2] <= cfg_data_i;
          tpag_pkg::REG_SIZE_AXIS_THREE: size_q[3] <= cfg_data_i;
          tpag_pkg::REG_AXIS_ORDER:      order_q   <= cfg_data_i[tpag_pkg::ORDER_W-1:0];
          default: ;
        endcase
      end
      busy_q <= busy_d;
      step_q <= step_d;
      run_q  <= run_d;
    end
  end

  // stride store, written one axis per cycle
  always_ff @(posedge clk_i) begin
    if (busy_q && !wr_hit) begin
      stride_q[src] <= run_q;
    end
  end

  // configuration view
  always_comb begin
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      cfg_o.stride[k] = stride_q[k];
    end
    cfg_o.ext       = ext;
    cfg_o.order_bad = (seen != '1);
    cfg_o.busy      = busy_q;
  end

`ifndef SYNTHESIS
  // a rebuild in progress runs to its last axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !cfg_we_i && step_q != '0) |=> busy_q)
    else $error("stride rebuild ended early");
`endif

endmodule

// ===== design/tpag_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpag_front
// Accepts elements, steps the source position counters, flags the last
// element and queues each transaction for the back end.
// ----------------------------------------------------------------------------
module tpag_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [tpag_pkg::ELEM_W-1:0]   element_in_i,
  output logic                          full_o,
  input  tpag_pkg::cfg_t                cfg_i,
  input  logic                          mid_pop_i,
  output logic                          mid_empty_o,
  output tpag_pkg::mid_t                mid_head_o
);

  tpag_pkg::pos_t                   pos_q [tpag_pkg::MAX_AXES];
  tpag_pkg::mid_t                   mem_q [tpag_pkg::MID_DEPTH];
  logic [tpag_pkg::MID_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [tpag_pkg::MID_PTR_W:0]     cnt_q;

  logic [tpag_pkg::MAX_AXES-1:0]    at_end;
  logic [tpag_pkg::MAX_AXES-1:0]    inc_en;
  logic                             accept;
  logic                             pop_ok;
  tpag_pkg::mid_t                   entry;

  assign full_o = (cnt_q == (tpag_pkg::MID_PTR_W+1)'(tpag_pkg::MID_DEPTH)) || cfg_i.busy;
  assign accept = push_i && !full_o;
  assign pop_ok = mid_pop_i && (cnt_q != '0);

  // end-of-axis detection and carry chain from the innermost axis
  always_comb begin
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      at_end[k] = tpag_pkg::EXT_W'(pos_q[k]) >= (cfg_i.ext[k] - tpag_pkg::EXT_W'(1));
    end
    inc_en[tpag_pkg::MAX_AXES-1] = 1'b1;
    for (int k = tpag_pkg::MAX_AXES - 1; k > 0; k--) begin
      inc_en[k-1] = inc_en[k] && at_end[k];
    end
  end

  // classified transaction
  always_comb begin
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      entry.pos[k] = pos_q[k];
    end
    entry.last = &at_end;
    entry.elem = element_in_i;
  end

  // position counters and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
        pos_q[k] <= '0;
      end
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
          if (inc_en[k]) begin
            pos_q[k] <= at_end[k] ? '0 : pos_q[k] + 1'b1;
          end
        end
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (accept && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!accept && pop_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  assign mid_empty_o = (cnt_q == '0);
  assign mid_head_o  = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (tpag_pkg::MID_PTR_W+1)'(tpag_pkg::MID_DEPTH))
    else $error("front queue overflow");

  // an accepted transaction without a pop grows the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pop_ok) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("front queue count lost a transaction");
`endif

endmodule

// ===== design/tpag_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpag_back
// Turns queued source positions into destination offsets: a multiply stage,
// an adder tree over two stages, and the result queue.
// ----------------------------------------------------------------------------
module tpag_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpag_pkg::cfg_t    cfg_i,
  input  logic              mid_empty_i,
  input  tpag_pkg::mid_t    mid_head_i,
  output logic              mid_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tpag_pkg::res_t    res_o
);

  localparam int OCC_W = tpag_pkg::OUT_PTR_W + 2;

  // stage 1: products
  logic                              v1_q;
  tpag_pkg::off_t [tpag_pkg::MAX_AXES-1:0] prod_q;
  logic [tpag_pkg::ELEM_W-1:0]       elem1_q;
  logic                              last1_q;

  // stage 2: pair sums
  logic                              v2_q;
  tpag_pkg::off_t                    sum_a_q, sum_b_q;
  logic [tpag_pkg::ELEM_W-1:0]       elem2_q;
  logic                              last2_q;

  // result queue
  tpag_pkg::res_t                    mem_q [tpag_pkg::OUT_DEPTH];
  logic [tpag_pkg::OUT_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [tpag_pkg::OUT_PTR_W:0]      cnt_q;

  logic [OCC_W-1:0]                  occ;
  logic                              issue;
  logic                              pop_ok;
  logic [tpag_pkg::DIM_BITS+tpag_pkg::OFF_W-1:0] prod_full [tpag_pkg::MAX_AXES];
  tpag_pkg::off_t                    sum_all;
  tpag_pkg::res_t                    res_new;

  // issue only with room for everything in flight
  assign occ       = OCC_W'(cnt_q) + OCC_W'(v1_q) + OCC_W'(v2_q);
  assign issue     = !mid_empty_i && (occ < OCC_W'(tpag_pkg::OUT_DEPTH));
  assign mid_pop_o = issue;
  assign empty_o   = (cnt_q == '0);
  assign pop_ok    = pop_i && !empty_o;

  // per-axis products
  always_comb begin
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      prod_full[k] = mid_head_i.pos[k] * cfg_i.stride[k];
    end
  end

  // final sum, forced to zero for a bad axis order
  assign sum_all      = sum_a_q + sum_b_q;
  assign res_new.off  = cfg_i.order_bad ? '0 : sum_all;
  assign res_new.elem = elem2_q;
  assign res_new.last = last2_q;
  assign res_new.err  = cfg_i.order_bad;

  // pipeline valids and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (v2_q && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!v2_q && pop_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      prod_q[k] <= prod_full[k][tpag_pkg::OFF_W-1:0];
    end
    elem1_q <= mid_head_i.elem;
    last1_q <= mid_head_i.last;
    sum_a_q <= prod_q[0] + prod_q[1];
    sum_b_q <= prod_q[2] + prod_q[3];
    elem2_q <= elem1_q;
    last2_q <= last1_q;
    if (v2_q) begin
      mem_q[wr_ptr_q] <= res_new;
    end
  end

  assign res_o = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  // queued plus in-flight results fit the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_W'(tpag_pkg::OUT_DEPTH))
    else $error("result queue overbooked");

  // a delivered result with nothing arriving shrinks the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !v2_q) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("result queue count mismatch");
`endif

endmodule

// ===== test/tb_tensor_permute_address_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tensor_permute_address_gen
// Self-checking bench for the tensor permute address generator. Elements are
// pushed through the input queue and results popped under random idling. A
// model of the source position odometer and the destination strides predicts
// each result, and every popped transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_tensor_permute_address_gen;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 150;
  localparam int TARGET_ITEMS   = 900;
  localparam int MAX_REPORTS    = 10;

  localparam logic [tpag_pkg::ORDER_W-1:0]   ORDER_REVERSED  = 8'h1B;
  // every field names axis zero
  localparam logic [tpag_pkg::ORDER_W-1:0]   ORDER_COLLAPSED = 8'h00;
  localparam logic [tpag_pkg::REG_IDX_W-1:0] REG_UNUSED_LOW  = tpag_pkg::REG_AXIS_ORDER + 3'd1;
  localparam logic [tpag_pkg::REG_IDX_W-1:0] REG_UNUSED_HIGH = '1;

  typedef struct {
    tpag_pkg::off_t              offset;
    logic [tpag_pkg::ELEM_W-1:0] element;
    logic                        last;
    logic                        err;
  } permute_result_t;

  // dut ports
  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           push         = 1'b0;
  logic                           pop          = 1'b0;
  logic [tpag_pkg::ELEM_W-1:0]    element_in_i = '0;
  logic                           cfg_we_i     = 1'b0;
  logic [tpag_pkg::REG_IDX_W-1:0] cfg_index_i  = '0;
  logic [tpag_pkg::CFG_W-1:0]     cfg_data_i   = '0;
  logic                           full;
  logic                           empty;
  tpag_pkg::off_t                 dest_offset_o;
  logic [tpag_pkg::ELEM_W-1:0]    element_out_o;
  logic                           last_of_tensor_o;
  logic                           order_error_o;

  // register copies and predicted block state
  logic [tpag_pkg::SIZE_W-1:0]  size_shadow [tpag_pkg::MAX_AXES];
  logic [tpag_pkg::ORDER_W-1:0] order_shadow;
  tpag_pkg::off_t               dest_stride [tpag_pkg::MAX_AXES];
  logic                         order_bad;
  tpag_pkg::pos_t               src_pos [tpag_pkg::MAX_AXES];

  logic [tpag_pkg::ELEM_W-1:0] pending_elements [$];
  permute_result_t             expected_results [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int tx_gap       = 0;
  int rx_gap       = 0;
  int hold_cnt     = 0;
  bit hold_done    = 1'b0;
  int stuck_cycles = 0;
  int mismatch_cnt = 0;
  bit failed       = 1'b0;
  int items_queued = 0;

  tensor_permute_address_gen dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .element_in_i     (element_in_i),
    .empty            (empty),
    .pop              (pop),
    .dest_offset_o    (dest_offset_o),
    .element_out_o    (element_out_o),
    .last_of_tensor_o (last_of_tensor_o),
    .order_error_o    (order_error_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // effective extent of a source axis
  function automatic int unsigned axis_extent(input int k);
    int unsigned sz;
    sz = size_shadow[k];
    if (k < tpag_pkg::MAX_AXES - tpag_pkg::AXES) return 1;
    if (sz == 0) return 1;
    if (sz > (1 << tpag_pkg::DIM_BITS)) return 1 << tpag_pkg::DIM_BITS;
    return sz;
  endfunction

  // destination stride of each source axis, innermost destination axis first
  function automatic void rebuild_dest_strides();
    logic [tpag_pkg::MAX_AXES-1:0] seen;
    logic [tpag_pkg::FIELD_W-1:0]  src;
    tpag_pkg::off_t                run;
    seen = '0;
    run  = tpag_pkg::OFF_W'(1);
    for (int i = 0; i < tpag_pkg::MAX_AXES; i++)
      seen[order_shadow[tpag_pkg::FIELD_W*i +: tpag_pkg::FIELD_W]] = 1'b1;
    order_bad = (seen != '1);
    for (int i = 0; i < tpag_pkg::MAX_AXES; i++) dest_stride[i] = '0;
    if (!order_bad) begin
      for (int i = tpag_pkg::MAX_AXES - 1; i >= 0; i--) begin
        src              = order_shadow[tpag_pkg::FIELD_W*i +: tpag_pkg::FIELD_W];
        dest_stride[src] = run;
        run              = run * tpag_pkg::OFF_W'(axis_extent(src));
      end
    end
  endfunction

  // expected result of one element, then step the source odometer
  function automatic permute_result_t permute_element(
      input logic [tpag_pkg::ELEM_W-1:0] value);
    permute_result_t r;
    tpag_pkg::off_t  off;
    off    = '0;
    r.last = 1'b1;
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      off = off + tpag_pkg::OFF_W'(src_pos[k]) * dest_stride[k];
      if (int'(src_pos[k]) < int'(axis_extent(k)) - 1) r.last = 1'b0;
    end
    r.offset  = order_bad ? '0 : off;
    r.element = value;
    r.err     = order_bad;
    // a counter at or past its end wraps, the first one that is not advances
    for (int k = tpag_pkg::MAX_AXES - 1; k >= 0; k--) begin
      if (int'(src_pos[k]) >= int'(axis_extent(k)) - 1) begin
        src_pos[k] = '0;
      end else begin
        src_pos[k] = src_pos[k] + 1'b1;
        break;
      end
    end
    return r;
  endfunction

  function automatic void report_mismatch(input string what,
                                          input logic [tpag_pkg::ELEM_W-1:0] want_v,
                                          input logic [tpag_pkg::ELEM_W-1:0] got_v);
    failed = 1'b1;
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
  endfunction

  task automatic check_result();
    permute_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected transaction, element", '0, element_out_o);
    end else begin
      want = expected_results.pop_front();
      if (dest_offset_o !== want.offset)
        report_mismatch("dest_offset", tpag_pkg::ELEM_W'(want.offset),
                        tpag_pkg::ELEM_W'(dest_offset_o));
      if (element_out_o !== want.element)
        report_mismatch("element_out", want.element, element_out_o);
      if (last_of_tensor_o !== want.last)
        report_mismatch("last_of_tensor", tpag_pkg::ELEM_W'(want.last),
                        tpag_pkg::ELEM_W'(last_of_tensor_o));
      if (order_error_o !== want.err)
        report_mismatch("order_error", tpag_pkg::ELEM_W'(want.err),
                        tpag_pkg::ELEM_W'(order_error_o));
    end
  endtask

  // register write, copied into the model once the block has taken it
  task automatic write_reg(input logic [tpag_pkg::REG_IDX_W-1:0] idx,
                           input logic [tpag_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= tpag_pkg::REG_SIZE_AXIS_THREE)
      size_shadow[idx - tpag_pkg::REG_SIZE_AXIS_ZERO] = data[tpag_pkg::SIZE_W-1:0];
    else if (idx == tpag_pkg::REG_AXIS_ORDER)
      order_shadow = data[tpag_pkg::ORDER_W-1:0];
    rebuild_dest_strides();
  endtask

  // wait until every queued element has come back, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_elements.size() != 0 || push || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_elements(input int n);
    logic [tpag_pkg::ELEM_W-1:0] v;
    @(negedge clk_i);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = '1;
        default: v = {$urandom, $urandom};
      endcase
      pending_elements.insert(pending_elements.size(), v);
    end
    items_queued += n;
    wait_idle();
  endtask

  // mostly small extents, now and then zero, the largest or oversize
  function automatic logic [tpag_pkg::CFG_W-1:0] random_extent();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return tpag_pkg::CFG_W'(1 << tpag_pkg::DIM_BITS);
      2:       return tpag_pkg::CFG_W'($urandom_range((1 << tpag_pkg::DIM_BITS) + 1,
                                                      (1 << tpag_pkg::SIZE_W) - 1));
      3:       return tpag_pkg::CFG_W'(1);
      4:       return tpag_pkg::CFG_W'($urandom_range(6, 40));
      default: return tpag_pkg::CFG_W'($urandom_range(2, 5));
    endcase
  endfunction

  // shuffled permutation, sometimes arbitrary fields
  function automatic logic [tpag_pkg::ORDER_W-1:0] random_axis_order();
    logic [tpag_pkg::FIELD_W-1:0] axis [tpag_pkg::MAX_AXES];
    logic [tpag_pkg::FIELD_W-1:0] t;
    logic [tpag_pkg::ORDER_W-1:0] ord;
    int                           j;
    for (int i = 0; i < tpag_pkg::MAX_AXES; i++) axis[i] = tpag_pkg::FIELD_W'(i);
    for (int i = tpag_pkg::MAX_AXES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = axis[i];
      axis[i] = axis[j];
      axis[j] = t;
    end
    for (int i = 0; i < tpag_pkg::MAX_AXES; i++)
      ord[tpag_pkg::FIELD_W*i +: tpag_pkg::FIELD_W] = axis[i];
    if ($urandom_range(0, 7) == 0) ord = tpag_pkg::ORDER_W'($urandom_range(0, 255));
    return ord;
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 30;
    endcase
  endfunction

  // driver: offers pending elements and predicts each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (push && !full)
        expected_results.insert(expected_results.size(), permute_element(element_in_i));
      if (!push || !full) begin
        if (tx_gap != 0) begin
          push   <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_elements.size() != 0 && tx_idle_pct != 0 &&
                     $urandom_range(0, 99) < tx_idle_pct) begin
          push   <= 1'b0;
          tx_gap <= $urandom_range(0, 7);
        end else if (pending_elements.size() != 0) begin
          push         <= 1'b1;
          element_in_i <= pending_elements.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pops results, with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      rx_gap   <= 0;
      hold_cnt <= 0;
    end else begin
      if (pop && !empty) check_result();
      if (hold_cnt != 0) begin
        pop      <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if (!hold_done && pending_elements.size() > 40) begin
        pop       <= 1'b0;
        hold_done <= 1'b1;
        hold_cnt  <= LONG_HOLD;
      end else if (rx_gap != 0) begin
        pop    <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        pop    <= 1'b0;
        rx_gap <= $urandom_range(0, 7);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles", $time, stuck_cycles);
      $display("[tensor_permute_address_gen] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned vol;
    int          n;
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
      size_shadow[k] = tpag_pkg::SIZE_RESET;
      src_pos[k]     = '0;
    end
    order_shadow = tpag_pkg::ORDER_RESET;
    rebuild_dest_strides();
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: every element is the last of its tensor
    @(negedge clk_i);
    pending_elements.insert(pending_elements.size(), '0);
    pending_elements.insert(pending_elements.size(), '1);
    pending_elements.insert(pending_elements.size(), {(tpag_pkg::ELEM_W/4){4'h5}});
    pending_elements.insert(pending_elements.size(), {(tpag_pkg::ELEM_W/4){4'hA}});
    wait_idle();

    // full transpose of a 2x1x1x3 tensor
    write_reg(tpag_pkg::REG_SIZE_AXIS_ZERO, tpag_pkg::CFG_W'(2));
    write_reg(tpag_pkg::REG_SIZE_AXIS_THREE, tpag_pkg::CFG_W'(3));
    write_reg(tpag_pkg::REG_AXIS_ORDER, tpag_pkg::CFG_W'(ORDER_REVERSED));
    send_elements(6);

    // axis order that is not a permutation
    write_reg(tpag_pkg::REG_AXIS_ORDER, tpag_pkg::CFG_W'(ORDER_COLLAPSED));
    send_elements(3);

    // writes beyond the register list, zero and oversize extents
    write_reg(REG_UNUSED_LOW, tpag_pkg::CFG_W'($urandom));
    write_reg(REG_UNUSED_HIGH, tpag_pkg::CFG_W'($urandom));
    write_reg(tpag_pkg::REG_SIZE_AXIS_ZERO, '0);
    write_reg(tpag_pkg::REG_SIZE_AXIS_THREE, '1);
    write_reg(tpag_pkg::REG_AXIS_ORDER, {5'h1F, tpag_pkg::ORDER_RESET});
    send_elements(4);

    // shrink the inner extent below its running counter
    write_reg(tpag_pkg::REG_SIZE_AXIS_THREE, tpag_pkg::CFG_W'(2));
    send_elements(3);

    // long phase, the receiver holds off early and the input backs up
    tx_idle_pct = 10;
    write_reg(tpag_pkg::REG_SIZE_AXIS_ZERO, tpag_pkg::CFG_W'(1));
    write_reg(tpag_pkg::REG_SIZE_AXIS_ONE, tpag_pkg::CFG_W'(3));
    write_reg(tpag_pkg::REG_SIZE_AXIS_TWO, tpag_pkg::CFG_W'(5));
    write_reg(tpag_pkg::REG_SIZE_AXIS_THREE, tpag_pkg::CFG_W'(8));
    write_reg(tpag_pkg::REG_AXIS_ORDER, tpag_pkg::CFG_W'(ORDER_REVERSED));
    send_elements(120);

    // largest extents on every axis
    for (int k = 0; k < tpag_pkg::MAX_AXES; k++)
      write_reg(tpag_pkg::REG_IDX_W'(tpag_pkg::REG_SIZE_AXIS_ZERO + k),
                tpag_pkg::CFG_W'(1 << tpag_pkg::DIM_BITS));
    send_elements(60);

    // random geometries, counters carry over between settings
    while (items_queued < TARGET_ITEMS) begin
      if (items_queued >= TARGET_ITEMS - 120) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else begin
        tx_idle_pct  = idle_share();
        rx_stall_pct = idle_share();
      end
      for (int k = 0; k < tpag_pkg::MAX_AXES; k++)
        if ($urandom_range(0, 3) != 0)
          write_reg(tpag_pkg::REG_IDX_W'(tpag_pkg::REG_SIZE_AXIS_ZERO + k), random_extent());
      if ($urandom_range(0, 3) != 0)
        write_reg(tpag_pkg::REG_AXIS_ORDER, {5'($urandom), random_axis_order()});
      if ($urandom_range(0, 9) == 0)
        write_reg(tpag_pkg::REG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_HIGH)),
                  tpag_pkg::CFG_W'($urandom));
      vol = 1;
      for (int k = 0; k < tpag_pkg::MAX_AXES; k++) begin
        vol = vol * axis_extent(k);
        if (vol > 1000) vol = 1000;
      end
      n = (vol <= 120) ? vol * $urandom_range(1, 2) : $urandom_range(10, 80);
      if (n > TARGET_ITEMS - items_queued) n = TARGET_ITEMS - items_queued;
      send_elements(n);
    end

    wait_idle();
    if (!failed && expected_results.size() == 0) begin
      $display("[tensor_permute_address_gen] OK");
    end else begin
      $display("[tensor_permute_address_gen] ERROR");
    end
    $finish;
  end

endmodule
